// ===== rtl/core/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// shared constants, status codes and inter-stage types of the serial day to
// calendar date converter
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

	// input range and special serial
	localparam logic [21:0] SERIAL_MAX     = 22'd2958465;
	localparam logic [21:0] PHANTOM_SERIAL = 22'd60;

	// julian day bias plus the first Fliegel-Van Flandern offset (68569 + 2415019)
	localparam logic [22:0] JD_BIAS = 23'd2483588;

	// century split: q = 4a / 146097, reciprocal floor(2^25 / 146097)
	localparam int          CENT_SHIFT = 25;
	localparam logic [24:0] CENT_DAYS4 = 25'd146097;
	localparam logic [7:0]  CENT_RECIP = 8'd229;

	// year split: q = 4000(a+1) / 1461001, reciprocal floor(2^28 / 1461001)
	localparam int          YEAR_SHIFT = 28;
	localparam logic [11:0] YEAR_SCALE = 12'd4000;
	localparam logic [27:0] YEAR_DIV   = 28'd1461001;
	localparam logic [7:0]  YEAR_RECIP = 8'd183;
	localparam logic [10:0] YEAR_DAYS4 = 11'd1461;

	// month split: q = 80a / 2447, reciprocal 80 * floor(2^17 / 2447)
	localparam int          MONTH_SHIFT   = 17;
	localparam logic [12:0] MONTH_RECIP80 = 13'd4240;
	localparam logic [11:0] MONTH_DIV     = 12'd2447;

	// year window
	localparam logic [13:0] YEAR_LOW  = 14'd1900;
	localparam logic [13:0] YEAR_HIGH = 14'd2100;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_RANGE  = 2'd1,
		STATUS_WINDOW = 2'd2
	} status_t;

	typedef struct packed {
		logic range_err;
		logic phantom;
	} flags_t;

	// century stage result
	typedef struct packed {
		logic [7:0]  n;
		logic [15:0] a1;
		flags_t      flags;
	} cent_t;

	// year stage result
	typedef struct packed {
		logic [9:0]  a2;
		logic [13:0] ybase;
		flags_t      flags;
	} yr_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdc_if.sv =====
// ----------------------------------------------------------------------------
// sdc channel interfaces
// valid/ready channels for serial day items and calendar date items
// ----------------------------------------------------------------------------
`default_nettype none

interface sdc_serial_if;
	logic        valid;
	logic        ready;
	logic [21:0] serial_day;

	modport source (output valid, output serial_day, input ready);
	modport sink   (input valid, input serial_day, output ready);
endinterface

interface sdc_date_if;
	logic        valid;
	logic        ready;
	logic        date_valid;
	logic [1:0]  status;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [13:0] year_number;

	modport source (
		output valid, output date_valid, output status, output day_of_month,
		output month_number, output year_number, input ready
	);
	modport sink (
		input valid, input date_valid, input status, input day_of_month,
		input month_number, input year_number, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/serial_day_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// serial_day_to_calendar_date
// spreadsheet serial day number to gregorian day, month and year
// ----------------------------------------------------------------------------
// Converts one serial day (1 = 1900-01-01) per item into day, month and year.
// The block takes one item every clock cycle while the output is not
// stalled, in an eleven-stage pipeline where each constant-reciprocal
// multiply and each remainder correction has a stage of its own. Every
// stage holds its item with a valid bit and moves on whenever the stage
// after it is empty or moving, so a stall at the output only backs up as
// far as there are full stages and bubbles close up. Serial 0 and serials
// above 2958465 give status 1 with zero date fields. Serial 60 gives the
// fictitious 29 Feb 1900 as a valid date. Dates outside 1900..2100, or days
// that do not fit the month, carry the computed fields with date_valid low
// and status 2.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_day_to_calendar_date
	import sdc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sdc_serial_if.sink  serial_in,
	sdc_date_if.source  date_out
);

	// century stage -> year stage
	logic  cent_valid;
	logic  cent_ready;
	cent_t cent_data;

	// year stage -> month stage
	logic  yr_valid;
	logic  yr_ready;
	yr_t   yr_data;

	// stages 1-3: range check, phantom day, julian day, 400-year cycle split
	sdc_century u_century (
		.clk       (clk),
		.arst_n    (arst_n),
		.serial_in (serial_in),
		.out_valid (cent_valid),
		.out_ready (cent_ready),
		.out_data  (cent_data)
	);

	// stages 4-7: year in century, day count within the year
	sdc_year u_year (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cent_valid),
		.in_ready  (cent_ready),
		.in_data   (cent_data),
		.out_valid (yr_valid),
		.out_ready (yr_ready),
		.out_data  (yr_data)
	);

	// stages 8-11: month and day, validity window, output register
	sdc_month u_month (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (yr_valid),
		.in_ready (yr_ready),
		.in_data  (yr_data),
		.date_out (date_out)
	);

endmodule

`default_nettype wire

// ===== rtl/core/sdc_century.sv =====
// ----------------------------------------------------------------------------
// sdc_century
// stages 1-3: serial adjust, range flags, julian day and 400-year split
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_century
	import sdc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sdc_serial_if.sink  serial_in,
	output logic        out_valid,
	input  wire logic   out_ready,
	output cent_t       out_data
);

	logic        vld_s1, vld_s2, vld_s3;
	logic        adv_s1, adv_s2, adv_s3;
	logic [22:0] a0_s1, a0_s2;
	flags_t      flg_s1, flg_s2, flg_s3;
	logic [7:0]  q1_s2;
	logic [7:0]  n_s3;
	logic [15:0] a1_s3;

	logic [21:0] s_adj;
	flags_t      flg_in;
	logic [32:0] prod1;
	logic [24:0] x1, r1, rc1;
	logic        ge1;

	assign adv_s3 = !vld_s3 || out_ready;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign serial_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= serial_in.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
		end
	end

	// step over the phantom leap day for early serials
	always_comb begin
		s_adj = (serial_in.serial_day < PHANTOM_SERIAL) ?
			serial_in.serial_day + 22'd1 : serial_in.serial_day;
		flg_in.range_err = (serial_in.serial_day == '0) ||
			(serial_in.serial_day > SERIAL_MAX);
		flg_in.phantom = (serial_in.serial_day == PHANTOM_SERIAL);
	end

	// quotient estimate, low by at most one
	assign prod1 = {8'd0, a0_s1, 2'b00} * {25'd0, CENT_RECIP};

	// remainder correction; the new day count is the remainder over four
	always_comb begin
		x1  = {a0_s2, 2'b00};
		r1  = x1 - ({17'd0, q1_s2} * CENT_DAYS4);
		ge1 = (r1 >= CENT_DAYS4);
		rc1 = ge1 ? r1 - CENT_DAYS4 : r1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			a0_s1  <= {1'b0, s_adj} + JD_BIAS;
			flg_s1 <= flg_in;
		end
		if (adv_s2) begin
			q1_s2  <= prod1[CENT_SHIFT +: 8];
			a0_s2  <= a0_s1;
			flg_s2 <= flg_s1;
		end
		if (adv_s3) begin
			n_s3   <= q1_s2 + {7'd0, ge1};
			a1_s3  <= rc1[17:2];
			flg_s3 <= flg_s2;
		end
	end

	assign out_valid      = vld_s3;
	assign out_data.n     = n_s3;
	assign out_data.a1    = a1_s3;
	assign out_data.flags = flg_s3;

endmodule

`default_nettype wire

// ===== rtl/core/sdc_year.sv =====
// ----------------------------------------------------------------------------
// sdc_year
// stages 4-7: year within the century and day of year
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_year
	import sdc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire cent_t in_data,
	output logic       out_valid,
	input  wire logic  out_ready,
	output yr_t        out_data
);

	localparam logic [17:0] DAY_BIAS  = 18'd31;
	localparam logic [13:0] CENT_BASE = 14'd49;
	localparam logic [13:0] CENT_YRS  = 14'd100;

	logic        vld_s4, vld_s5, vld_s6, vld_s7;
	logic        adv_s4, adv_s5, adv_s6, adv_s7;
	logic [27:0] x2_s4, x2_s5;
	logic [15:0] a1_s4, a1_s5, a1_s6;
	logic [7:0]  n_s4, n_s5, n_s6;
	flags_t      flg_s4, flg_s5, flg_s6, flg_s7;
	logic [6:0]  q2_s5, i_s6;
	logic [9:0]  a2_s7;
	logic [13:0] ybase_s7;

	logic [27:0] x2;
	logic [35:0] prod2;
	logic [27:0] r2;
	logic        ge2;
	logic [17:0] t2;

	assign adv_s7   = !vld_s7 || out_ready;
	assign adv_s6   = !vld_s6 || adv_s7;
	assign adv_s5   = !vld_s5 || adv_s6;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign in_ready = adv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s4) vld_s4 <= in_valid;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	always_comb begin
		x2    = ({12'd0, in_data.a1} + 28'd1) * {16'd0, YEAR_SCALE};
		prod2 = {8'd0, x2_s4} * {28'd0, YEAR_RECIP};
		r2    = x2_s5 - ({21'd0, q2_s5} * YEAR_DIV);
		ge2   = (r2 >= YEAR_DIV);
		t2    = {2'b00, a1_s6} + DAY_BIAS -
			(({11'd0, i_s6} * {7'd0, YEAR_DAYS4}) >> 2);
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			x2_s4  <= x2;
			a1_s4  <= in_data.a1;
			n_s4   <= in_data.n;
			flg_s4 <= in_data.flags;
		end
		if (adv_s5) begin
			q2_s5  <= prod2[YEAR_SHIFT +: 7];
			x2_s5  <= x2_s4;
			a1_s5  <= a1_s4;
			n_s5   <= n_s4;
			flg_s5 <= flg_s4;
		end
		if (adv_s6) begin
			i_s6   <= q2_s5 + {6'd0, ge2};
			a1_s6  <= a1_s5;
			n_s6   <= n_s5;
			flg_s6 <= flg_s5;
		end
		if (adv_s7) begin
			a2_s7    <= t2[9:0];
			ybase_s7 <= (({6'd0, n_s6} - CENT_BASE) * CENT_YRS) + {7'd0, i_s6};
			flg_s7   <= flg_s6;
		end
	end

	assign out_valid      = vld_s7;
	assign out_data.a2    = a2_s7;
	assign out_data.ybase = ybase_s7;
	assign out_data.flags = flg_s7;

endmodule

`default_nettype wire

// ===== rtl/core/sdc_month.sv =====
// ----------------------------------------------------------------------------
// sdc_month
// stages 8-11: month and day split, validity checks, output register
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_month
	import sdc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire yr_t    in_data,
	sdc_date_if.source  date_out
);

	localparam logic [16:0] MONTH_SCALE = 17'd80;
	localparam logic [11:0] CEIL_BIAS   = 12'd79;
	localparam logic [15:0] FIFTH_MUL   = 16'd205;
	localparam logic [5:0]  MONTH_SPAN  = 6'd12;

	logic        vld_s8, vld_s9, vld_s10, vld_s11;
	logic        adv_s8, adv_s9, adv_s10, adv_s11;
	logic [9:0]  a2_s8;
	logic [5:0]  q3_s8, j_s9;
	logic [11:0] rem_s9;
	logic [13:0] ybase_s8, ybase_s9;
	flags_t      flg_s8, flg_s9, flg_s10;
	logic [4:0]  d_s10;
	logic [5:0]  m_s10;
	logic [13:0] y_s10;
	logic        ok_s11;
	status_t     status_s11;
	logic [4:0]  d_s11;
	logic [3:0]  m_s11;
	logic [13:0] y_s11;

	logic [22:0] prod3;
	logic [16:0] x3, r3, rc3;
	logic        ge3;
	logic [11:0] t3;
	logic [15:0] p3;
	logic [1:0]  k3;
	logic        leap;
	logic        ok;
	logic [4:0]  mlen;

	function automatic logic [4:0] month_len(input logic [5:0] m, input logic lp);
		logic [4:0] len;
		case (m)
			6'd1, 6'd3, 6'd5, 6'd7, 6'd8, 6'd10, 6'd12: len = 5'd31;
			6'd4, 6'd6, 6'd9, 6'd11:                    len = 5'd30;
			6'd2:                                       len = lp ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	assign adv_s11  = !vld_s11 || date_out.ready;
	assign adv_s10  = !vld_s10 || adv_s11;
	assign adv_s9   = !vld_s9 || adv_s10;
	assign adv_s8   = !vld_s8 || adv_s9;
	assign in_ready = adv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			if (adv_s8)  vld_s8  <= in_valid;
			if (adv_s9)  vld_s9  <= vld_s8;
			if (adv_s10) vld_s10 <= vld_s9;
			if (adv_s11) vld_s11 <= vld_s10;
		end
	end

	always_comb begin
		prod3 = {13'd0, in_data.a2} * {10'd0, MONTH_RECIP80};
		x3    = {7'd0, a2_s8} * MONTH_SCALE;
		r3    = x3 - ({11'd0, q3_s8} * {5'd0, MONTH_DIV});
		ge3   = (r3 >= {5'd0, MONTH_DIV});
		rc3   = ge3 ? r3 - {5'd0, MONTH_DIV} : r3;
		// day is the remainder over 80, rounded up: (r + 79) / 16 / 5
		t3    = rem_s9 + CEIL_BIAS;
		p3    = {8'd0, t3[11:4]} * FIFTH_MUL;
		if (j_s9 >= 6'd33)      k3 = 2'd3;
		else if (j_s9 >= 6'd22) k3 = 2'd2;
		else if (j_s9 >= 6'd11) k3 = 2'd1;
		else                    k3 = 2'd0;
		// only 1900, 2000 and 2100 are century years inside the window
		leap  = (y_s10[1:0] == 2'b00) && (y_s10 != YEAR_LOW) && (y_s10 != YEAR_HIGH);
		mlen  = month_len(m_s10, leap);
		ok    = (y_s10 >= YEAR_LOW) && (y_s10 <= YEAR_HIGH) &&
			(m_s10 >= 6'd1) && (m_s10 <= MONTH_SPAN) &&
			(d_s10 != 5'd0) && (d_s10 <= mlen);
	end

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			q3_s8    <= prod3[MONTH_SHIFT +: 6];
			a2_s8    <= in_data.a2;
			ybase_s8 <= in_data.ybase;
			flg_s8   <= in_data.flags;
		end
		if (adv_s9) begin
			j_s9     <= q3_s8 + {5'd0, ge3};
			rem_s9   <= rc3[11:0];
			ybase_s9 <= ybase_s8;
			flg_s9   <= flg_s8;
		end
		if (adv_s10) begin
			d_s10   <= p3[14:10];
			m_s10   <= j_s9 + 6'd2 - ({4'd0, k3} * MONTH_SPAN);
			y_s10   <= ybase_s9 + {12'd0, k3};
			flg_s10 <= flg_s9;
		end
		if (adv_s11) begin
			if (flg_s10.range_err) begin
				ok_s11     <= 1'b0;
				status_s11 <= STATUS_RANGE;
				d_s11      <= '0;
				m_s11      <= '0;
				y_s11      <= '0;
			end else if (flg_s10.phantom) begin
				ok_s11     <= 1'b1;
				status_s11 <= STATUS_OK;
				d_s11      <= 5'd29;
				m_s11      <= 4'd2;
				y_s11      <= YEAR_LOW;
			end else begin
				ok_s11     <= ok;
				status_s11 <= ok ? STATUS_OK : STATUS_WINDOW;
				d_s11      <= d_s10;
				m_s11      <= m_s10[3:0];
				y_s11      <= y_s10;
			end
		end
	end

	assign date_out.valid        = vld_s11;
	assign date_out.date_valid   = ok_s11;
	assign date_out.status       = status_s11;
	assign date_out.day_of_month = d_s11;
	assign date_out.month_number = m_s11;
	assign date_out.year_number  = y_s11;

endmodule

`default_nettype wire

// ===== rtl/core/sdc_checker.sv =====
// ----------------------------------------------------------------------------
// sdc_checker
// port-level checks on the date channel of the converter
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_checker
	import sdc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        date_valid,
	input wire logic [1:0]  status,
	input wire logic [4:0]  day_of_month,
	input wire logic [3:0]  month_number,
	input wire logic [13:0] year_number
);

	// a range error carries no date
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_RANGE |->
			!date_valid && day_of_month == '0 && month_number == '0 &&
			year_number == '0)
		else $error("range error item with nonzero date");

	// valid flag and status agree
	a_valid_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (date_valid == (status == STATUS_OK)) &&
			(status == STATUS_OK || status == STATUS_RANGE || status == STATUS_WINDOW))
		else $error("date_valid and status disagree");

	// a valid date lies inside the window
	a_valid_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid |->
			month_number >= 4'd1 && month_number <= 4'd12 &&
			day_of_month >= 5'd1 && day_of_month <= 5'd31 &&
			year_number >= YEAR_LOW && year_number <= YEAR_HIGH)
		else $error("valid date outside window");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(date_valid) &&
			$stable(status) && $stable(day_of_month) && $stable(month_number) &&
			$stable(year_number))
		else $error("stalled result changed");

endmodule

bind serial_day_to_calendar_date sdc_checker u_sdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (date_out.valid),
	.out_ready    (date_out.ready),
	.date_valid   (date_out.date_valid),
	.status       (date_out.status),
	.day_of_month (date_out.day_of_month),
	.month_number (date_out.month_number),
	.year_number  (date_out.year_number)
);

`default_nettype wire
